// ----- src/nir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_pkg: shared types and constants for the inverse square root block
// Item formats, fixed-point constants, register indexes and core states.
// ----------------------------------------------------------------------------
package nir_pkg;

    // Field widths
    localparam int VALUE_W   = 24;  // Q2.22 operand and root
    localparam int GUESS_W   = 32;  // Q8.24 inverse root guess
    localparam int THRESH_W  = 24;  // Q0.24 error bound
    localparam int LIMIT_W   = 10;  // step limit register
    localparam int STEPS_W   = 10;  // steps_taken field
    localparam int SQ_W      = 40;  // g*g in Q.24
    localparam int GAIN_W    = 42;  // g*g*x in Q.24
    localparam int FAC_W     = 26;  // 3 - g*g*x in Q.24 when positive
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // Fixed-point constants in Q.24
    localparam logic [GAIN_W-1:0] ONE_Q24   = GAIN_W'(64'd1 << 24);
    localparam logic [GAIN_W-1:0] THREE_Q24 = GAIN_W'(64'd3 << 24);

    // Register reset values
    localparam logic [GUESS_W-1:0]  GUESS_RST  = 32'h0100_0000;
    localparam logic [THRESH_W-1:0] THRESH_RST = 24'd168;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 10'd1023;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GUESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd2;

    // Depth of the queue between front and core
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_value;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] root;
        logic               converged;
        logic [STEPS_W-1:0] steps_taken;
        logic               last_result;
    } out_item_t;

    // Classified item handed from front to core
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_value;
        logic               zero;
    } task_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SQUARE,
        CS_GAIN,
        CS_CHECK,
        CS_STEP,
        CS_ROOT,
        CS_EMIT
    } core_state_t;

endpackage

// ----- src/nir_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_front: input side of the inverse square root block
// Accepts items and marks a zero operand, which can never converge.
// ----------------------------------------------------------------------------
module nir_front
    import nir_pkg::*;
(
    input  logic     push,
    input  logic     full,
    input  in_item_t in_item,
    output logic     wr_en,
    output task_t    wr_task
);

    // Accept when the queue has room
    assign wr_en = push & ~full;

    // Classify the operand
    always_comb
    begin
        wr_task.value      = in_item.value;
        wr_task.last_value = in_item.last_value;
        wr_task.zero       = (in_item.value == '0);
    end

endmodule

// ----- src/nir_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_queue: short queue between front and core
// Holds classified items so that each side can stall on its own.
// ----------------------------------------------------------------------------
module nir_queue
    import nir_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  task_t wr_task,
    output logic  full,
    output logic  rd_valid,
    output task_t rd_task,
    input  logic  rd_take
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    task_t              mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_rd;

    assign full     = (count_reg == CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_task  = mem_reg[rd_ptr_reg];
    assign do_rd    = rd_take & rd_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_task;
        end
    end

endmodule

// ----- src/nir_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_core: Newton iteration engine and result register
// Runs g <- g*(3 - g*g*x)/2 until the error is within bound or the step
// limit is hit, then forms root = x*g and holds it for the consumer.
// ----------------------------------------------------------------------------
module nir_core
    import nir_pkg::*;
#(
    parameter int STEP_COUNT_BITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  task_t               q_task,
    output logic                q_take,
    input  logic [GUESS_W-1:0]  cfg_guess,
    input  logic [THRESH_W-1:0] cfg_threshold,
    input  logic [LIMIT_W-1:0]  cfg_limit,
    output out_item_t           out_item,
    output logic                empty,
    input  logic                pop
);

    localparam int LW = (STEP_COUNT_BITS > LIMIT_W) ? STEP_COUNT_BITS : LIMIT_W;
    localparam logic [LW-1:0] CAP = LW'((64'd1 << STEP_COUNT_BITS) - 64'd1);

    core_state_t        state_reg;
    core_state_t        state_next;

    // Datapath registers
    logic [VALUE_W-1:0] x_reg;
    logic               last_reg;
    logic [GUESS_W-1:0] g_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [GAIN_W-1:0]  e_reg;
    logic [FAC_W-1:0]   fac_reg;
    logic               neg_reg;
    logic [LW-1:0]      steps_reg;
    logic               done_reg;
    logic [VALUE_W-1:0] root_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    // Strobes from the sequencer
    logic               ld_sq;
    logic               ld_e;
    logic               ld_chk;
    logic               ld_step;
    logic               ld_root;
    logic               emit;

    logic [LW-1:0]      limit_ext;
    logic [LW-1:0]      limit;
    logic               slot_free;
    logic [63:0]        sq_prod;
    logic [63:0]        e_prod;
    logic [GAIN_W-1:0]  err;
    logic [GAIN_W-1:0]  fac_diff;
    logic               in_bound;
    logic               at_limit;
    logic [57:0]        step_prod;
    logic [32:0]        step_sh;
    logic [GUESS_W-1:0] g_step;
    logic [55:0]        root_prod;
    logic [31:0]        root_sh;
    logic [VALUE_W-1:0] root_sat;

    // Effective step limit, capped by the counter range
    assign limit_ext = LW'(cfg_limit);
    assign limit     = (limit_ext > CAP) ? CAP : limit_ext;
    assign at_limit  = (steps_reg == limit);

    assign slot_free = ~out_valid_reg | pop;

    // g*g and g*g*x in Q.24
    assign sq_prod = 64'(g_reg) * 64'(g_reg);
    assign e_prod  = 64'(sq_reg) * 64'(x_reg);

    // Error against one and the Newton factor
    assign err      = (e_reg >= ONE_Q24) ? (e_reg - ONE_Q24) : (ONE_Q24 - e_reg);
    assign in_bound = (err <= GAIN_W'(cfg_threshold));
    assign fac_diff = THREE_Q24 - e_reg;

    // Newton step: clamp a diverging guess to zero, saturate overflow
    assign step_prod = 58'(g_reg) * 58'(fac_reg);
    assign step_sh   = step_prod[57:25];
    assign g_step    = neg_reg ? '0 : (step_sh[32] ? '1 : step_sh[31:0]);

    // Root = x*g, saturated to Q2.22
    assign root_prod = 56'(x_reg) * 56'(g_reg);
    assign root_sh   = root_prod[55:24];
    assign root_sat  = (root_sh[31:24] != '0) ? '1 : root_sh[23:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_task.zero ? CS_ROOT : CS_SQUARE;
                end
            end
            CS_SQUARE: state_next = CS_GAIN;
            CS_GAIN:   state_next = CS_CHECK;
            CS_CHECK:
            begin
                state_next = (in_bound || at_limit) ? CS_ROOT : CS_STEP;
            end
            CS_STEP:   state_next = CS_SQUARE;
            CS_ROOT:   state_next = CS_EMIT;
            CS_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:   state_next = CS_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        q_take  = 1'b0;
        ld_sq   = 1'b0;
        ld_e    = 1'b0;
        ld_chk  = 1'b0;
        ld_step = 1'b0;
        ld_root = 1'b0;
        emit    = 1'b0;
        case (state_reg)
            CS_IDLE:   q_take  = q_valid;
            CS_SQUARE: ld_sq   = 1'b1;
            CS_GAIN:   ld_e    = 1'b1;
            CS_CHECK:  ld_chk  = 1'b1;
            CS_STEP:   ld_step = 1'b1;
            CS_ROOT:   ld_root = 1'b1;
            CS_EMIT:   emit    = slot_free;
            default:   q_take  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Iteration datapath
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            x_reg     <= q_task.value;
            last_reg  <= q_task.last_value;
            g_reg     <= cfg_guess;
            steps_reg <= q_task.zero ? limit : '0;
            done_reg  <= 1'b0;
        end
        if (ld_sq)
        begin
            sq_reg <= sq_prod[63:24];
        end
        if (ld_e)
        begin
            e_reg <= e_prod[63:22];
        end
        if (ld_chk)
        begin
            done_reg <= in_bound;
            neg_reg  <= (e_reg >= THREE_Q24);
            fac_reg  <= fac_diff[FAC_W-1:0];
        end
        if (ld_step)
        begin
            g_reg     <= g_step;
            steps_reg <= steps_reg + 1'b1;
        end
        if (ld_root)
        begin
            root_reg <= root_sat;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the finished item
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.root        <= root_reg;
            out_reg.converged   <= done_reg;
            out_reg.steps_taken <= steps_reg[STEPS_W-1:0];
            out_reg.last_result <= last_reg;
        end
    end

    assign out_item = out_reg;
    assign empty    = ~out_valid_reg;

endmodule

// ----- src/newton_inverse_sqrt_root_top.sv -----
`timescale 1ns / 1ps
// Each Newton step walks the core's sequencer through square, gain, check and step;
// a zero operand goes straight to forming the root. The single iteration engine
// takes a new item only once the last one's result is in the output register;
// up to two items wait in the input queue and one result in the output register.
// Reset (rst_n, async, active low) empties the input queue and the result register
// and restores the registers to guess 1.0, threshold 168 and step limit 1023.
// ----------------------------------------------------------------------------
// newton_inverse_sqrt_root_top: Newton-Raphson square root block
// Front classifier, item queue, iteration core and configuration registers.
// ----------------------------------------------------------------------------
module newton_inverse_sqrt_root_top
    import nir_pkg::*;
#(
    parameter int STEP_COUNT_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             in_item,
    output logic                 empty,
    input  logic                 pop,
    output out_item_t            out_item,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [GUESS_W-1:0]  guess_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic  wr_en;
    task_t wr_task;
    logic  rd_valid;
    task_t rd_task;
    logic  rd_take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guess_reg  <= GUESS_RST;
            thresh_reg <= THRESH_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INITIAL_GUESS:   guess_reg  <= cfg_data[GUESS_W-1:0];
                CFG_ERROR_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                CFG_ITERATION_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:             limit_reg  <= limit_reg;
            endcase
        end
    end

    // Accept and classify
    nir_front u_front
    (
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .wr_en   (wr_en),
        .wr_task (wr_task)
    );

    // Decouple front and core
    nir_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_task  (wr_task),
        .full     (full),
        .rd_valid (rd_valid),
        .rd_task  (rd_task),
        .rd_take  (rd_take)
    );

    // Iterate and deliver
    nir_core #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (rd_valid),
        .q_task        (rd_task),
        .q_take        (rd_take),
        .cfg_guess     (guess_reg),
        .cfg_threshold (thresh_reg),
        .cfg_limit     (limit_reg),
        .out_item      (out_item),
        .empty         (empty),
        .pop           (pop)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Newton-Raphson square root block
// A clocked driver feeds items and register writes from a stimulus queue that
// is filled up front. A built-in predictor computes the expected root,
// converged flag, step count and last flag for every accepted item. A clocked
// monitor pops results under random stalls and checks each one, field by
// field, against the oldest prediction. Registers are only rewritten once
// every outstanding result has come back.
// ----------------------------------------------------------------------------
module testbench;
    import nir_pkg::*;

    localparam int STEP_BITS      = 10;
    localparam int WATCHDOG_LIMIT = 50000;  // cycles without any handshake
    localparam int HOLD_AT        = 60;     // results seen before the long hold
    localparam int HOLD_CYCLES    = 1500;
    localparam int TAIL_CYCLES    = 16;

    typedef enum logic [1:0] {
        STIM_ITEM,
        STIM_DRAIN,
        STIM_CFG
    } stim_kind_t;

    typedef struct {
        stim_kind_t           kind;
        in_item_t             item;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } stim_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    in_item_t             in_item   = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    out_item_t            out_item;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Register copies used by the predictor
    logic [GUESS_W-1:0]  guess_q  = GUESS_RST;
    logic [THRESH_W-1:0] thresh_q = THRESH_RST;
    logic [LIMIT_W-1:0]  limit_q  = LIMIT_RST;

    stim_t     stim_q[$];
    out_item_t root_expect_q[$];

    int items_sent   = 0;
    int results_seen = 0;
    int failures     = 0;
    bit stim_done    = 1'b0;
    int burst_left   = 8;
    int gap_left     = 0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int idle_cycles  = 0;

    newton_inverse_sqrt_root_top #(
        .STEP_COUNT_BITS(STEP_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // g*g*x in Q.24, truncating at each product
    function automatic logic [63:0] gain_q24(logic [63:0] g, logic [63:0] x);
        logic [63:0] sq;
        sq = (g * g) >> 24;
        return (sq * x) >> 22;
    endfunction

    function automatic bit within_bound(logic [63:0] e);
        logic [63:0] err;
        err = (e >= 64'(ONE_Q24)) ? e - 64'(ONE_Q24) : 64'(ONE_Q24) - e;
        return err <= 64'(thresh_q);
    endfunction

    // Run the Newton iteration on one item under the current register copies
    function automatic out_item_t sqrt_by_newton(in_item_t it);
        logic [63:0] x;
        logic [63:0] g;
        logic [63:0] e;
        logic [63:0] lim;
        logic [63:0] steps;
        logic [63:0] root;
        bit          done;
        out_item_t   res;
        x     = 64'(it.value);
        g     = 64'(guess_q);
        lim   = 64'(limit_q);
        steps = '0;
        if (lim > (64'd1 << STEP_BITS) - 1)
            lim = (64'd1 << STEP_BITS) - 1;
        e    = gain_q24(g, x);
        done = within_bound(e);
        while (!done && steps < lim)
        begin
            // clamp a diverging guess to zero, else step and saturate
            if (e >= 64'(THREE_Q24))
                g = '0;
            else
            begin
                g = (g * (64'(THREE_Q24) - e)) >> 25;
                if (g > 64'hFFFF_FFFF)
                    g = 64'hFFFF_FFFF;
            end
            steps++;
            e    = gain_q24(g, x);
            done = within_bound(e);
        end
        root = (x * g) >> 24;
        if (root > 64'hFF_FFFF)
            root = 64'hFF_FFFF;
        res.root        = root[VALUE_W-1:0];
        res.converged   = done;
        res.steps_taken = steps[STEPS_W-1:0];
        res.last_result = it.last_value;
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(bit in_range);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (in_range)
            return VALUE_W'($urandom_range(24'h10_0000, 24'hBF_FFFF));
        if (pick < 70)
            return VALUE_W'($urandom_range(256, 24'hBF_FFFF));
        if (pick < 80)
            return VALUE_W'($urandom_range(0, 255));
        if (pick < 85)
            return pick[0] ? 24'hFF_FFFF : 24'h00_0000;
        return VALUE_W'($urandom);
    endfunction

    task automatic queue_item(logic [VALUE_W-1:0] value, logic last);
        stim_t s;
        s.kind             = STIM_ITEM;
        s.item.value       = value;
        s.item.last_value  = last;
        s.index            = '0;
        s.data             = '0;
        stim_q.push_back(s);
    endtask

    // Wait for the block to drain, then rewrite all three registers
    task automatic queue_settings(logic [GUESS_W-1:0] guess, logic [THRESH_W-1:0] thr,
                                  logic [LIMIT_W-1:0] lim);
        stim_t s;
        s.kind  = STIM_DRAIN;
        s.item  = '0;
        s.index = '0;
        s.data  = '0;
        stim_q.push_back(s);
        s.kind  = STIM_CFG;
        s.index = CFG_INITIAL_GUESS;
        s.data  = CFG_W'(guess);
        stim_q.push_back(s);
        s.index = CFG_ERROR_THRESHOLD;
        s.data  = CFG_W'(thr);
        stim_q.push_back(s);
        s.index = CFG_ITERATION_LIMIT;
        s.data  = CFG_W'(lim);
        stim_q.push_back(s);
    endtask

    // Driver: offer items in bursts, hold until taken, write registers when idle
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        logic                 nxt_push;
        in_item_t             nxt_item;
        logic                 nxt_wr;
        logic [CFG_IDX_W-1:0] nxt_index;
        logic [CFG_W-1:0]     nxt_data;
        int                   sent_now;
        if (!rst_n)
        begin
            push       <= 1'b0;
            in_item    <= '0;
            cfg_wr_en  <= 1'b0;
            cfg_index  <= '0;
            cfg_data   <= '0;
            items_sent <= 0;
            stim_done  <= 1'b0;
        end
        else
        begin
            nxt_push  = 1'b0;
            nxt_item  = in_item;
            nxt_wr    = 1'b0;
            nxt_index = cfg_index;
            nxt_data  = cfg_data;
            sent_now  = items_sent;
            // retire the accepted item and predict its result
            if (push && !full)
            begin
                root_expect_q.push_back(sqrt_by_newton(in_item));
                void'(stim_q.pop_front());
                sent_now++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
            if (push && full)
                nxt_push = 1'b1;
            else if (stim_q.size() != 0)
            begin
                case (stim_q[0].kind)
                    STIM_ITEM:
                    begin
                        if (gap_left > 0)
                            gap_left--;
                        else
                        begin
                            nxt_push = 1'b1;
                            nxt_item = stim_q[0].item;
                        end
                    end
                    STIM_DRAIN:
                    begin
                        if (results_seen == sent_now)
                            void'(stim_q.pop_front());
                    end
                    STIM_CFG:
                    begin
                        nxt_wr    = 1'b1;
                        nxt_index = stim_q[0].index;
                        nxt_data  = stim_q[0].data;
                        case (stim_q[0].index)
                            CFG_INITIAL_GUESS:   guess_q  = stim_q[0].data[GUESS_W-1:0];
                            CFG_ERROR_THRESHOLD: thresh_q = stim_q[0].data[THRESH_W-1:0];
                            CFG_ITERATION_LIMIT: limit_q  = stim_q[0].data[LIMIT_W-1:0];
                            default: ;
                        endcase
                        void'(stim_q.pop_front());
                    end
                    default: ;
                endcase
            end
            push       <= nxt_push;
            in_item    <= nxt_item;
            cfg_wr_en  <= nxt_wr;
            cfg_index  <= nxt_index;
            cfg_data   <= nxt_data;
            items_sent <= sent_now;
            stim_done  <= (stim_q.size() == 0) && !nxt_push;
        end
    end

    // Monitor: check each popped result, stall on a pattern of its own
    always @(posedge clk or negedge rst_n)
    begin : check_results
        out_item_t want;
        logic      nxt_pop;
        if (!rst_n)
        begin
            pop          <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (root_expect_q.size() == 0)
                begin
                    $error("unexpected result: root %0h", out_item.root);
                    failures++;
                end
                else
                begin
                    want = root_expect_q.pop_front();
                    if (out_item.root !== want.root)
                    begin
                        $error("root: expected %0h, got %0h", want.root, out_item.root);
                        failures++;
                    end
                    if (out_item.converged !== want.converged)
                    begin
                        $error("converged: expected %0d, got %0d",
                               want.converged, out_item.converged);
                        failures++;
                    end
                    if (out_item.steps_taken !== want.steps_taken)
                    begin
                        $error("steps_taken: expected %0d, got %0d",
                               want.steps_taken, out_item.steps_taken);
                        failures++;
                    end
                    if (out_item.last_result !== want.last_result)
                    begin
                        $error("last_result: expected %0d, got %0d",
                               want.last_result, out_item.last_result);
                        failures++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            // hold off once for a long stretch so the block backs up
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_pop = 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                nxt_pop   = 1'b0;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                case (stall_mode)
                    0:       nxt_pop = 1'b1;
                    1:       nxt_pop = ($urandom_range(0, 3) != 0);
                    default: nxt_pop = ($urandom_range(0, 7) == 0);
                endcase
            end
            pop <= nxt_pop;
        end
    end

    // Watchdog: give up when no handshake happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin : run_stimulus
        logic [GUESS_W-1:0]  guess;
        logic [THRESH_W-1:0] thr;
        logic [LIMIT_W-1:0]  lim;
        int                  count;
        bit                  in_range;

        // Directed: already converged, zero, extremes, diverging, tiny values
        queue_item(24'h40_0000, 1'b1);
        queue_item(24'h00_0000, 1'b0);
        queue_item(24'hFF_FFFF, 1'b0);
        queue_item(24'hC0_0000, 1'b0);
        queue_item(24'hBF_FFFF, 1'b0);
        queue_item(24'h00_0001, 1'b0);
        queue_item(24'h80_0000, 1'b1);
        queue_item(24'h55_5555, 1'b0);
        queue_item(24'hAA_AAAA, 1'b1);
        queue_item(24'h01_0000, 1'b0);
        queue_item(24'h00_0040, 1'b0);
        // no steps allowed: the flag reflects the starting guess
        queue_settings(GUESS_RST, THRESH_RST, '0);
        queue_item(24'h40_0000, 1'b0);
        queue_item(24'h80_0000, 1'b1);
        queue_item(24'h00_0000, 1'b0);
        // zero guess never moves, widest threshold, one step
        queue_settings('0, 24'hFF_FFFF, 10'd1);
        queue_item(24'h12_3456, 1'b1);
        queue_item(24'hFF_FFFF, 1'b0);

        // Random phases, each under its own register setting
        for (int p = 0; p < 8; p++)
        begin
            in_range = 1'b0;
            case (p)
                0:
                begin
                    guess = GUESS_RST;
                    thr   = THRESH_RST;
                    lim   = LIMIT_W'($urandom_range(4, 12));
                    count = 110;
                end
                1:
                begin
                    guess = '0;
                    thr   = '0;
                    lim   = 10'd1;
                    count = 100;
                end
                2:
                begin
                    guess = '1;
                    thr   = '1;
                    lim   = LIMIT_W'($urandom_range(1, 16));
                    count = 100;
                end
                3:
                begin
                    guess    = GUESS_RST;
                    thr      = THRESH_W'($urandom_range(168, 4096));
                    lim      = LIMIT_RST;
                    count    = 50;
                    in_range = 1'b1;
                end
                default:
                begin
                    guess = $urandom_range(0, 1) ? $urandom_range(32'h0040_0000, 32'h0400_0000)
                                                 : $urandom;
                    thr   = $urandom_range(0, 1) ? THRESH_W'($urandom_range(0, 1023))
                                                 : THRESH_W'($urandom_range(0, 24'hFF_FFFF));
                    lim   = LIMIT_W'($urandom_range(1, 48));
                    count = 120;
                end
            endcase
            queue_settings(guess, thr, lim);
            for (int i = 0; i < count; i++)
                queue_item(pick_value(in_range), 1'($urandom_range(0, 1)));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last item to go in and every result to come out
        do
            @(posedge clk);
        while (!stim_done || results_seen != items_sent);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (root_expect_q.size() != 0)
        begin
            $error("%0d expected results never arrived", root_expect_q.size());
            failures++;
        end
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- newton_inverse_sqrt_root_top.f -----
src/nir_pkg.sv
src/nir_front.sv
src/nir_queue.sv
src/nir_core.sv
src/newton_inverse_sqrt_root_top.sv
tb/sv/testbench.sv
